// File: rtl/kcrl_pkg.sv
// Package for the keyed compacting record list.
// Holds command and status codes, controller states, payload widths and the cell control struct.
// No dependencies.
package kcrl_pkg;

   // Payload widths on the request and response channels
   localparam int CMD_W    = 2;
   localparam int KEY_W    = 16;
   localparam int DATA_W   = 32;
   localparam int STATUS_W = 3;

   typedef enum logic [CMD_W-1:0] {
      CMD_INSERT = 2'd0,
      CMD_REMOVE = 2'd1,
      CMD_UPDATE = 2'd2,
      CMD_LIST   = 2'd3
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      STS_DONE      = 3'd0,
      STS_FULL      = 3'd1,
      STS_NOT_FOUND = 3'd2,
      STS_RECORD    = 3'd3,
      STS_EMPTY     = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_INSERT,
      ST_SEARCH,
      ST_LIST
   } state_type;

   // Control broadcast from the controller to every cell
   typedef struct packed {
      logic start;    // put the scan token on the first cell
      logic advance;  // move the scan token one cell up
      logic insert;   // tail cell loads the write record
      logic remove;   // cells at or above the token take their upper neighbor
      logic update;   // token cell loads the write record
   } cell_ctl_type;

endpackage

// File: rtl/kcrl_req_if.sv
// Request channel of the keyed compacting record list.
// Depends on kcrl_pkg for payload widths.
interface kcrl_req_if;
   logic                        valid;
   logic                        ready;
   logic [kcrl_pkg::CMD_W-1:0]  cmd;
   logic [kcrl_pkg::KEY_W-1:0]  key;
   logic [kcrl_pkg::KEY_W-1:0]  new_key;
   logic [kcrl_pkg::DATA_W-1:0] data_word;

   modport source (output valid, output cmd, output key, output new_key, output data_word,
                   input ready);
   modport sink   (input valid, input cmd, input key, input new_key, input data_word,
                   output ready);
endinterface

// File: rtl/kcrl_rsp_if.sv
// Response channel of the keyed compacting record list.
// Depends on kcrl_pkg for payload widths.
interface kcrl_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [kcrl_pkg::STATUS_W-1:0] status;
   logic [kcrl_pkg::KEY_W-1:0]    out_key;
   logic [kcrl_pkg::DATA_W-1:0]   out_data;
   logic                          last;

   modport source (output valid, output status, output out_key, output out_data, output last,
                   input ready);
   modport sink   (input valid, input status, input out_key, input out_data, input last,
                   output ready);
endinterface

// File: rtl/kcrl_cell.sv
// One cell of the record list: holds one record plus the scan token and its passed flag.
// Depends on kcrl_pkg for the cell control struct.
module kcrl_cell #(
   parameter int INDEX      = 0,
   parameter int LIST_DEPTH = 16,
   parameter int KEY_BITS   = 16,
   parameter int DATA_BITS  = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  kcrl_pkg::cell_ctl_type            ctl,
   input  logic [$clog2(LIST_DEPTH+1)-1:0]   count,
   input  logic [KEY_BITS-1:0]               srch_key,
   input  logic [KEY_BITS-1:0]               wr_key,
   input  logic [DATA_BITS-1:0]              wr_data,
   input  logic                              tok_in,
   input  logic [KEY_BITS-1:0]               next_key,
   input  logic [DATA_BITS-1:0]              next_data,
   output logic                              tok_out,
   output logic [KEY_BITS-1:0]               key_q,
   output logic [DATA_BITS-1:0]              data_q,
   output logic                              hit,
   output logic                              sel,
   output logic                              sel_last
);
   localparam int CNT_BITS = $clog2(LIST_DEPTH+1);
   localparam logic [CNT_BITS-1:0] IDX_C  = CNT_BITS'(INDEX);
   localparam logic [CNT_BITS-1:0] NEXT_C = CNT_BITS'(INDEX + 1);
   localparam logic                FIRST  = (INDEX == 0);

   logic                 tok_ff, tok_in_next;
   logic                 passed_ff, passed_in;
   logic [KEY_BITS-1:0]  key_ff, key_in;
   logic [DATA_BITS-1:0] data_ff, data_in;
   logic                 live;
   logic                 tail;

   assign live = IDX_C < count;
   assign tail = IDX_C == count;

   // Move the token and remember the cells it has left behind
   always_comb begin
      tok_in_next = tok_ff;
      passed_in   = passed_ff;
      if (ctl.start) begin
         tok_in_next = FIRST;
         passed_in   = 1'b0;
      end else if (ctl.advance) begin
         tok_in_next = tok_in;
         passed_in   = passed_ff | tok_ff;
      end
   end

   // Load a new record, overwrite the matched one, or close the gap
   always_comb begin
      key_in  = key_ff;
      data_in = data_ff;
      if ((ctl.insert && tail) || (ctl.update && tok_ff)) begin
         key_in  = wr_key;
         data_in = wr_data;
      end else if (ctl.remove && (tok_ff || !passed_ff)) begin
         key_in  = next_key;
         data_in = next_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff    <= 1'b0;
         passed_ff <= 1'b0;
      end else begin
         tok_ff    <= tok_in_next;
         passed_ff <= passed_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff  <= key_in;
      data_ff <= data_in;
   end

   assign tok_out  = tok_ff;
   assign key_q    = key_ff;
   assign data_q   = data_ff;
   assign sel      = tok_ff & live;
   assign hit      = sel & (key_ff == srch_key);
   assign sel_last = sel & (NEXT_C == count);

endmodule

// File: rtl/keyed_compacting_record_list.sv
// Top level of the keyed compacting record list: controller, response register and cell row.
// Depends on kcrl_pkg, kcrl_req_if, kcrl_rsp_if and kcrl_cell.

// A bounded ordered list of key/data records held in a row of LIST_DEPTH cells, one record
// per cell, with a scan token that walks up the row one cell per cycle. The block works on
// one request at a time and accepts a new one only when the previous has issued all of its
// responses into the response register. Insert writes the tail cell unless the list is full.
// Remove and update walk the token from the first cell up to the first match, or to the
// record count when nothing matches; remove then closes the gap with the match cell and
// every cell above it copying its upper neighbor. List issues one response per cycle, one
// per stored record, while the response side keeps taking them; an empty list gives a
// single empty status. Keys are kept at KEY_BITS bits and data at DATA_BITS bits; wider
// request fields are truncated.
module keyed_compacting_record_list #(
   parameter int LIST_DEPTH = 16,
   parameter int KEY_BITS   = 16,
   parameter int DATA_BITS  = 32
) (
   input  logic       clock,
   input  logic       reset,
   kcrl_req_if.sink   req,
   kcrl_rsp_if.source rsp
);
   localparam int CNT_BITS = $clog2(LIST_DEPTH+1);
   localparam logic [CNT_BITS-1:0] FULL_C = CNT_BITS'(LIST_DEPTH);
   localparam logic [CNT_BITS-1:0] ONE_C  = CNT_BITS'(1);

   kcrl_pkg::state_type  state_ff, state_in;
   logic [CNT_BITS-1:0]  count_ff, count_in;
   kcrl_pkg::cmd_type    cmd_ff;
   logic [KEY_BITS-1:0]  key_ff, new_key_ff;
   logic [DATA_BITS-1:0] data_ff;

   logic                              rsp_valid_ff, rsp_valid_in;
   logic [kcrl_pkg::STATUS_W-1:0]     rsp_status_ff;
   logic [kcrl_pkg::KEY_W-1:0]        rsp_key_ff;
   logic [kcrl_pkg::DATA_W-1:0]       rsp_data_ff;
   logic                              rsp_last_ff;

   kcrl_pkg::cell_ctl_type ctl;
   logic                   accept;
   logic                   can_emit;
   logic                   emit;
   kcrl_pkg::status_type   emit_status;
   logic                   emit_record;
   logic                   emit_last;

   logic [LIST_DEPTH-1:0]  tok_vec, hit_vec, sel_vec, last_vec;
   logic [KEY_BITS-1:0]    cell_key  [LIST_DEPTH];
   logic [DATA_BITS-1:0]   cell_data [LIST_DEPTH];
   logic [KEY_BITS-1:0]    wr_key;
   logic                   any_hit, any_live, any_last;
   logic [KEY_BITS-1:0]    sel_key;
   logic [DATA_BITS-1:0]   sel_data;

   // Cell row: token moves up, records move down on remove
   for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_cell
      logic                 tok_prev;
      logic [KEY_BITS-1:0]  up_key;
      logic [DATA_BITS-1:0] up_data;

      if (i == 0) begin : g_head
         assign tok_prev = 1'b0;
      end else begin : g_body
         assign tok_prev = tok_vec[i-1];
      end

      if (i == LIST_DEPTH - 1) begin : g_top
         assign up_key  = cell_key[i];
         assign up_data = cell_data[i];
      end else begin : g_below
         assign up_key  = cell_key[i+1];
         assign up_data = cell_data[i+1];
      end

      kcrl_cell #(
         .INDEX      (i),
         .LIST_DEPTH (LIST_DEPTH),
         .KEY_BITS   (KEY_BITS),
         .DATA_BITS  (DATA_BITS)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctl       (ctl),
         .count     (count_ff),
         .srch_key  (key_ff),
         .wr_key    (wr_key),
         .wr_data   (data_ff),
         .tok_in    (tok_prev),
         .next_key  (up_key),
         .next_data (up_data),
         .tok_out   (tok_vec[i]),
         .key_q     (cell_key[i]),
         .data_q    (cell_data[i]),
         .hit       (hit_vec[i]),
         .sel       (sel_vec[i]),
         .sel_last  (last_vec[i])
      );
   end

   assign wr_key   = (cmd_ff == kcrl_pkg::CMD_INSERT) ? key_ff : new_key_ff;
   assign any_hit  = |hit_vec;
   assign any_live = |sel_vec;
   assign any_last = |last_vec;

   // Pick the record under the token (at most one cell is selected)
   always_comb begin
      sel_key  = '0;
      sel_data = '0;
      for (int i = 0; i < LIST_DEPTH; i++) begin
         sel_key  = sel_key  | (cell_key[i]  & {KEY_BITS{sel_vec[i]}});
         sel_data = sel_data | (cell_data[i] & {DATA_BITS{sel_vec[i]}});
      end
   end

   assign accept   = req.valid & req.ready;
   assign can_emit = !rsp_valid_ff || rsp.ready;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         kcrl_pkg::ST_IDLE: begin
            if (accept) begin
               unique case (kcrl_pkg::cmd_type'(req.cmd))
                  kcrl_pkg::CMD_INSERT: state_in = kcrl_pkg::ST_INSERT;
                  kcrl_pkg::CMD_LIST:   state_in = kcrl_pkg::ST_LIST;
                  default:              state_in = kcrl_pkg::ST_SEARCH;
               endcase
            end
         end
         kcrl_pkg::ST_INSERT: begin
            if (can_emit) state_in = kcrl_pkg::ST_IDLE;
         end
         kcrl_pkg::ST_SEARCH: begin
            if (can_emit && (any_hit || !any_live)) state_in = kcrl_pkg::ST_IDLE;
         end
         kcrl_pkg::ST_LIST: begin
            if (can_emit && (!any_live || any_last)) state_in = kcrl_pkg::ST_IDLE;
         end
         default: state_in = kcrl_pkg::ST_IDLE;
      endcase
   end

   // Controller outputs: cell control, count update and response load
   always_comb begin
      req.ready   = 1'b0;
      ctl         = '0;
      count_in    = count_ff;
      emit        = 1'b0;
      emit_status = kcrl_pkg::STS_DONE;
      emit_record = 1'b0;
      emit_last   = 1'b1;
      unique case (state_ff)
         kcrl_pkg::ST_IDLE: begin
            req.ready = 1'b1;
            ctl.start = accept && (kcrl_pkg::cmd_type'(req.cmd) != kcrl_pkg::CMD_INSERT);
         end
         kcrl_pkg::ST_INSERT: begin
            if (can_emit) begin
               emit = 1'b1;
               if (count_ff == FULL_C) begin
                  emit_status = kcrl_pkg::STS_FULL;
               end else begin
                  ctl.insert = 1'b1;
                  count_in   = count_ff + ONE_C;
               end
            end
         end
         kcrl_pkg::ST_SEARCH: begin
            if (any_hit) begin
               if (can_emit) begin
                  emit = 1'b1;
                  if (cmd_ff == kcrl_pkg::CMD_REMOVE) begin
                     ctl.remove  = 1'b1;
                     emit_record = 1'b1;
                     count_in    = count_ff - ONE_C;
                  end else begin
                     ctl.update = 1'b1;
                  end
               end
            end else if (!any_live) begin
               if (can_emit) begin
                  emit        = 1'b1;
                  emit_status = kcrl_pkg::STS_NOT_FOUND;
               end
            end else begin
               ctl.advance = 1'b1;
            end
         end
         kcrl_pkg::ST_LIST: begin
            if (can_emit) begin
               emit = 1'b1;
               if (!any_live) begin
                  emit_status = kcrl_pkg::STS_EMPTY;
               end else begin
                  emit_status = kcrl_pkg::STS_RECORD;
                  emit_record = 1'b1;
                  emit_last   = any_last;
                  ctl.advance = !any_last;
               end
            end
         end
         default: begin
            req.ready = 1'b0;
         end
      endcase
   end

   assign rsp_valid_in = emit || (rsp_valid_ff && !rsp.ready);

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= kcrl_pkg::ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Hold the request fields for the whole operation
   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff     <= kcrl_pkg::cmd_type'(req.cmd);
         key_ff     <= KEY_BITS'(req.key);
         new_key_ff <= KEY_BITS'(req.new_key);
         data_ff    <= DATA_BITS'(req.data_word);
      end
   end

   // Load the response register
   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_status_ff <= emit_status;
         rsp_last_ff   <= emit_last;
         rsp_key_ff    <= emit_record ? kcrl_pkg::KEY_W'(sel_key) : '0;
         rsp_data_ff   <= emit_record ? kcrl_pkg::DATA_W'(sel_data) : '0;
      end
   end

   assign rsp.valid    = rsp_valid_ff;
   assign rsp.status   = rsp_status_ff;
   assign rsp.out_key  = rsp_key_ff;
   assign rsp.out_data = rsp_data_ff;
   assign rsp.last     = rsp_last_ff;

   // The scan token sits on at most one cell
   a_tok_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0(tok_vec))
      else $error("scan token on more than one cell");

   // The record count never exceeds the row length
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_C)
      else $error("record count beyond list depth");

   // A remove drops exactly one record
   a_remove_count: assert property (@(posedge clock) disable iff (reset)
      ctl.remove |=> count_ff == $past(count_ff) - ONE_C)
      else $error("remove did not drop one record");

   // A pending response is never overwritten
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp.ready) |-> !emit)
      else $error("response register overwritten while stalled");

   // A request is taken only after the previous one has issued its final response
   a_accept_after_last: assert property (@(posedge clock) disable iff (reset)
      (emit && !emit_last) |=> state_ff != kcrl_pkg::ST_IDLE)
      else $error("controller went idle before the final response");

endmodule

// File: sim/keyed_compacting_record_list_test.sv
// Self-checking testbench for keyed_compacting_record_list: directed and random
// insert/remove/update/list requests under random and long response stalls.
// Depends on kcrl_pkg, kcrl_req_if, kcrl_rsp_if and the keyed_compacting_record_list RTL.
module keyed_compacting_record_list_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LIST_DEPTH  = 16;
   localparam int DRAIN_WAIT  = 2 * LIST_DEPTH + 8;
   localparam int CYCLE_LIMIT = 400000;

   typedef struct packed {
      kcrl_pkg::cmd_type           op;
      logic [kcrl_pkg::KEY_W-1:0]  key;
      logic [kcrl_pkg::KEY_W-1:0]  new_key;
      logic [kcrl_pkg::DATA_W-1:0] data_word;
   } list_request_type;

   typedef struct packed {
      kcrl_pkg::status_type        status;
      logic [kcrl_pkg::KEY_W-1:0]  out_key;
      logic [kcrl_pkg::DATA_W-1:0] out_data;
      logic                        last;
   } list_response_type;

   logic clock;
   logic reset = 1'b1;

   kcrl_req_if req_ch();
   kcrl_rsp_if rsp_ch();

   keyed_compacting_record_list #(
      .LIST_DEPTH(LIST_DEPTH),
      .KEY_BITS  (kcrl_pkg::KEY_W),
      .DATA_BITS (kcrl_pkg::DATA_W)
   ) u_dut (
      .clock(clock),
      .reset(reset),
      .req  (req_ch),
      .rsp  (rsp_ch)
   );

   // Shadow copy of the record list
   logic [kcrl_pkg::KEY_W-1:0]  record_keys [LIST_DEPTH];
   logic [kcrl_pkg::DATA_W-1:0] record_data [LIST_DEPTH];
   int                          record_count = 0;
   list_response_type           owed_responses[$];

   // Request staging between the test tasks and the request driver
   list_request_type staged;
   bit               staged_full   = 1'b0;
   bit               offer_open    = 1'b0;
   int               send_idle_pct = 0;
   int               rsp_idle_pct  = 0;
   int               rsp_hold_left = 0;

   // Bookkeeping
   int cmd_seen [4] = '{0, 0, 0, 0};
   int full_seen      = 0;
   int missed_seen    = 0;
   int empty_seen     = 0;
   int checked_count  = 0;
   int error_count    = 0;
   int cycle_count    = 0;

   logic [kcrl_pkg::KEY_W-1:0] key_pool [4] = '{16'h0000, 16'hFFFF, 16'h00A5, 16'h5A00};

   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   // Queue one expected response
   function automatic void owe_response(input kcrl_pkg::status_type status,
                                        input logic [kcrl_pkg::KEY_W-1:0] key,
                                        input logic [kcrl_pkg::DATA_W-1:0] data,
                                        input logic last);
      list_response_type rsp;
      rsp.status   = status;
      rsp.out_key  = key;
      rsp.out_data = data;
      rsp.last     = last;
      owed_responses.push_back(rsp);
   endfunction

   // Apply one accepted request to the shadow list and owe its responses
   function automatic void apply_request(input list_request_type rq);
      int hit;
      hit = -1;
      for (int i = 0; i < record_count; i++)
         if (hit < 0 && record_keys[i] == rq.key) hit = i;
      cmd_seen[rq.op]++;
      case (rq.op)
         kcrl_pkg::CMD_INSERT: begin
            if (record_count == LIST_DEPTH) begin
               full_seen++;
               owe_response(kcrl_pkg::STS_FULL, '0, '0, 1'b1);
            end else begin
               record_keys[record_count] = rq.key;
               record_data[record_count] = rq.data_word;
               record_count++;
               owe_response(kcrl_pkg::STS_DONE, '0, '0, 1'b1);
            end
         end
         kcrl_pkg::CMD_REMOVE: begin
            if (hit < 0) begin
               missed_seen++;
               owe_response(kcrl_pkg::STS_NOT_FOUND, '0, '0, 1'b1);
            end else begin
               owe_response(kcrl_pkg::STS_DONE, record_keys[hit], record_data[hit], 1'b1);
               for (int i = hit + 1; i < record_count; i++) begin
                  record_keys[i-1] = record_keys[i];
                  record_data[i-1] = record_data[i];
               end
               record_count--;
            end
         end
         kcrl_pkg::CMD_UPDATE: begin
            if (hit < 0) begin
               missed_seen++;
               owe_response(kcrl_pkg::STS_NOT_FOUND, '0, '0, 1'b1);
            end else begin
               record_keys[hit] = rq.new_key;
               record_data[hit] = rq.data_word;
               owe_response(kcrl_pkg::STS_DONE, '0, '0, 1'b1);
            end
         end
         default: begin
            if (record_count == 0) begin
               empty_seen++;
               owe_response(kcrl_pkg::STS_EMPTY, '0, '0, 1'b1);
            end else begin
               for (int i = 0; i < record_count; i++)
                  owe_response(kcrl_pkg::STS_RECORD, record_keys[i], record_data[i],
                               i == record_count - 1);
            end
         end
      endcase
   endfunction

   // Drive the request channel: hold an open offer, otherwise offer or idle
   always @(negedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else if (!offer_open) begin
         if (staged_full && $urandom_range(99) >= send_idle_pct) begin
            req_ch.valid     <= 1'b1;
            req_ch.cmd       <= staged.op;
            req_ch.key       <= staged.key;
            req_ch.new_key   <= staged.new_key;
            req_ch.data_word <= staged.data_word;
            offer_open = 1'b1;
         end else begin
            req_ch.valid     <= 1'b0;
            req_ch.key       <= kcrl_pkg::KEY_W'($urandom());
            req_ch.data_word <= $urandom();
         end
      end
   end

   // Drive the response ready: long hold-off first, then random stalls
   always @(negedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= (rsp_hold_left == 0) && ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   // Count down the long response hold-off
   always @(posedge clock) begin
      if (rsp_hold_left != 0) rsp_hold_left <= rsp_hold_left - 1;
   end

   // Predict on every accepted request
   always @(posedge clock) begin
      list_request_type rq;
      if (!reset && req_ch.valid && req_ch.ready) begin
         rq.op        = kcrl_pkg::cmd_type'(req_ch.cmd);
         rq.key       = req_ch.key;
         rq.new_key   = req_ch.new_key;
         rq.data_word = req_ch.data_word;
         apply_request(rq);
         offer_open  = 1'b0;
         staged_full = 1'b0;
      end
   end

   // Check every accepted response against the oldest owed one
   always @(posedge clock) begin
      list_response_type got;
      list_response_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got.status   = kcrl_pkg::status_type'(rsp_ch.status);
         got.out_key  = rsp_ch.out_key;
         got.out_data = rsp_ch.out_data;
         got.last     = rsp_ch.last;
         checked_count++;
         if (owed_responses.size() == 0) begin
            error_count++;
            $display("%0t: unexpected response status=%0d key=%h data=%h last=%b",
                     $time, got.status, got.out_key, got.out_data, got.last);
         end else begin
            want = owed_responses.pop_front();
            if (got !== want) begin
               error_count++;
               $display("%0t: response mismatch: expected status=%0d key=%h data=%h last=%b",
                        $time, want.status, want.out_key, want.out_data, want.last);
               $display("%0t:                    actual status=%0d key=%h data=%h last=%b",
                        $time, got.status, got.out_key, got.out_data, got.last);
            end
         end
      end
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles with %0d responses outstanding",
                  cycle_count, owed_responses.size());
         $display("Verification failed");
         $finish;
      end
   end

   // Stage one request and block until the list accepts it
   task automatic send_request(input kcrl_pkg::cmd_type op,
                               input logic [kcrl_pkg::KEY_W-1:0] key,
                               input logic [kcrl_pkg::KEY_W-1:0] new_key,
                               input logic [kcrl_pkg::DATA_W-1:0] data_word);
      staged.op        = op;
      staged.key       = key;
      staged.new_key   = new_key;
      staged.data_word = data_word;
      staged_full      = 1'b1;
      wait (!staged_full);
   endtask

   // Hold the sender until every owed response has arrived
   task automatic wait_until_drained();
      while (owed_responses.size() != 0) @(negedge clock);
      repeat (DRAIN_WAIT) @(negedge clock);
   endtask

   // Half the time a key already in the list, so searches hit and duplicates appear
   function automatic logic [kcrl_pkg::KEY_W-1:0] pick_key();
      int unsigned roll;
      roll = $urandom_range(9);
      if (roll < 5 && record_count != 0) return record_keys[$urandom_range(record_count - 1)];
      if (roll < 7) return key_pool[$urandom_range(3)];
      return kcrl_pkg::KEY_W'($urandom());
   endfunction

   task automatic test_empty_list();
      send_request(kcrl_pkg::CMD_LIST,   16'h0000, 16'h0000, 32'h0000_0000);
      send_request(kcrl_pkg::CMD_REMOVE, 16'hFFFF, 16'h0000, 32'h0000_0000);
      send_request(kcrl_pkg::CMD_UPDATE, 16'h0000, 16'hFFFF, 32'hFFFF_FFFF);
   endtask

   // Duplicate keys: only the lowest match is touched
   task automatic test_duplicate_keys();
      send_request(kcrl_pkg::CMD_INSERT, 16'h0000, 16'hFFFF, 32'h0000_0000);
      send_request(kcrl_pkg::CMD_INSERT, 16'hFFFF, 16'h0000, 32'hFFFF_FFFF);
      send_request(kcrl_pkg::CMD_INSERT, 16'h0000, 16'h1234, 32'h0000_0001);
      send_request(kcrl_pkg::CMD_LIST,   16'h5555, 16'hAAAA, 32'h5555_5555);
      send_request(kcrl_pkg::CMD_UPDATE, 16'h0000, 16'hFFFF, 32'h1234_5678);
      send_request(kcrl_pkg::CMD_REMOVE, 16'hFFFF, 16'h0000, 32'h0000_0000);
      send_request(kcrl_pkg::CMD_REMOVE, 16'h1234, 16'h0000, 32'h0000_0000);
   endtask

   // Fill to capacity, overflow once, list all, drop the tail record
   task automatic test_full_list();
      int fill;
      fill = LIST_DEPTH - record_count;
      for (int i = 0; i < fill; i++)
         send_request(kcrl_pkg::CMD_INSERT, 16'h1000 + kcrl_pkg::KEY_W'(i), 16'h0000,
                      $urandom());
      send_request(kcrl_pkg::CMD_INSERT, 16'hBEEF, 16'h0000, 32'hDEAD_BEEF);
      send_request(kcrl_pkg::CMD_LIST,   16'h0000, 16'h0000, 32'h0000_0000);
      send_request(kcrl_pkg::CMD_REMOVE, record_keys[LIST_DEPTH-1], 16'h0000, 32'h0000_0000);
   endtask

   // Stall the response side for a long stretch while requests keep coming
   task automatic test_response_stall();
      send_idle_pct = 0;
      rsp_idle_pct  = 0;
      @(negedge clock);
      rsp_hold_left = 160;
      for (int i = 0; i < 12; i++) begin
         if (i % 4 == 3)
            send_request(kcrl_pkg::CMD_LIST, 16'h0000, 16'h0000, 32'h0000_0000);
         else if (i % 4 == 2)
            send_request(kcrl_pkg::CMD_REMOVE, pick_key(), 16'h0000, 32'h0000_0000);
         else
            send_request(kcrl_pkg::CMD_INSERT, pick_key(), 16'h0000, $urandom());
      end
      wait_until_drained();
   endtask

   // Random traffic swinging between filling and emptying the list
   task automatic test_random_traffic(input int count, input int send_pct, input int rsp_pct);
      bit                filling;
      int unsigned       roll;
      kcrl_pkg::cmd_type op;
      send_idle_pct = send_pct;
      rsp_idle_pct  = rsp_pct;
      filling       = 1'b1;
      for (int i = 0; i < count; i++) begin
         if (record_count == LIST_DEPTH && $urandom_range(3) == 0) filling = 1'b0;
         if (record_count == 0 && $urandom_range(2) == 0) filling = 1'b1;
         roll = $urandom_range(99);
         if (filling)
            op = roll < 55 ? kcrl_pkg::CMD_INSERT : roll < 70 ? kcrl_pkg::CMD_REMOVE :
                 roll < 85 ? kcrl_pkg::CMD_UPDATE : kcrl_pkg::CMD_LIST;
         else
            op = roll < 15 ? kcrl_pkg::CMD_INSERT : roll < 60 ? kcrl_pkg::CMD_REMOVE :
                 roll < 80 ? kcrl_pkg::CMD_UPDATE : kcrl_pkg::CMD_LIST;
         send_request(op, pick_key(),
                      $urandom_range(1) ? pick_key() : kcrl_pkg::KEY_W'($urandom()),
                      $urandom());
      end
      wait_until_drained();
   endtask

   initial begin
      req_ch.valid     = 1'b0;
      req_ch.cmd       = kcrl_pkg::CMD_INSERT;
      req_ch.key       = '0;
      req_ch.new_key   = '0;
      req_ch.data_word = '0;
      rsp_ch.ready     = 1'b0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      send_idle_pct = 10;
      rsp_idle_pct  = 10;
      test_empty_list();
      test_duplicate_keys();
      test_full_list();
      wait_until_drained();

      test_random_traffic(78, 31, 61);
      test_response_stall();
      test_random_traffic(78, 61, 31);
      test_random_traffic(78, 0, 0);

      $display("Run covered %0d inserts, %0d removes, %0d updates, %0d listings; %0d responses",
               cmd_seen[kcrl_pkg::CMD_INSERT], cmd_seen[kcrl_pkg::CMD_REMOVE],
               cmd_seen[kcrl_pkg::CMD_UPDATE], cmd_seen[kcrl_pkg::CMD_LIST], checked_count);
      $display("Inserts into a full list %0d, searches without a match %0d, empty listings %0d",
               full_seen, missed_seen, empty_seen);
      if (error_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("%0d errors", error_count);
         $display("Verification failed");
      end
      $finish;
   end

endmodule

// File: keyed_compacting_record_list.f
rtl/kcrl_pkg.sv
rtl/kcrl_req_if.sv
rtl/kcrl_rsp_if.sv
rtl/kcrl_cell.sv
rtl/keyed_compacting_record_list.sv
sim/keyed_compacting_record_list_test.sv
